/* rtl/hlt_pkg.sv */
package hlt_pkg;

   localparam int FX_W = 17;
   localparam int DEN_W = 18;
   localparam logic [FX_W-1:0] FX_ONE = 17'h10000;
   localparam logic [FX_W-1:0] FX_HALF = 17'h08000;
   localparam logic [FX_W-1:0] FX_THIRD = 17'd21845;

   // restoring divider: quotient bits resolved per pipeline stage, fewer in the last
   localparam int DIV_STEP = 3;
   localparam int DIV_STAGES = (FX_W + DIV_STEP - 1) / DIV_STEP;

   // floor(h6 / 6) as (h6 * HUE_RECIP) >> HUE_RECIP_SHIFT, exact for h6 < 2^19
   localparam logic [17:0] HUE_RECIP = 18'd174763;
   localparam int HUE_RECIP_SHIFT = 20;

   // floor(m * 65536 / 100) = m*655 + floor(9m / 25), the latter by reciprocal
   localparam logic [9:0] SHIFT_INT = 10'd655;
   localparam logic [3:0] SHIFT_FRAC_MUL = 4'd9;
   localparam logic [11:0] SHIFT_RECIP = 12'd2622;

   localparam logic [7:0] SHIFT_RESET = 8'hEF;

   typedef struct packed {
      logic [FX_W-1:0] lum;
      logic [7:0] alpha;
      logic [2:0] base;
      logic neg;
      logic grey;
   } side_type;

endpackage

/* rtl/hlt_div.sv */
module hlt_div (
   input logic clock,
   input logic [hlt_pkg::DIV_STAGES-1:0] en,
   input logic [hlt_pkg::FX_W-1:0] num,
   input logic [hlt_pkg::DEN_W-1:0] den,
   output logic [hlt_pkg::FX_W-1:0] quo
);

   localparam int NS = hlt_pkg::DIV_STAGES;
   localparam int QW = hlt_pkg::FX_W;
   localparam int DW = hlt_pkg::DEN_W;

   logic [DW-1:0] rem_ff [NS];
   logic [DW-1:0] rem_in [NS];
   logic [DW-1:0] den_ff [NS];
   logic [DW-1:0] den_in [NS];
   logic [QW-1:0] quo_ff [NS];
   logic [QW-1:0] quo_in [NS];

   always_comb begin
      logic [DW-1:0] r;
      logic [DW-1:0] d;
      logic [QW-1:0] q;
      logic [DW:0] cand;
      int b;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            r = DW'(num);
            d = den;
            q = '0;
         end else begin
            r = rem_ff[k-1];
            d = den_ff[k-1];
            q = quo_ff[k-1];
         end
         for (int j = 0; j < hlt_pkg::DIV_STEP; j++) begin
            b = QW - 1 - k * hlt_pkg::DIV_STEP - j;
            if (b >= 0) begin
               // numerator is num << 16: the top step sees num itself, later ones shift in 0
               cand = (b == QW - 1) ? {1'b0, r} : {r, 1'b0};
               if (cand >= {1'b0, d}) begin
                  cand = cand - {1'b0, d};
                  q[b] = 1'b1;
               end
               r = cand[DW-1:0];
            end
         end
         rem_in[k] = r;
         den_in[k] = d;
         quo_in[k] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[NS-1];

endmodule

/* rtl/hsl_lightness_tint.sv */
// HSL lightness adjust for an RGBA pixel stream. One request per clock is
// accepted when the response side keeps up; a request passes through input
// conversion, min/max, six stages of the two restoring dividers for
// saturation and hue resolving up to three quotient bits each, then hue
// scaling, lightness shift, q and p, piece select, the three-channel
// hue-to-RGB multiply and byte scaling. Stalls fill bubbles first, so the
// block keeps taking requests while the pipeline has room. Write the
// lightness shift (signed percent, reset -17) only while idle.
module hsl_lightness_tint (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_red_in,
   input logic [7:0] req_green_in,
   input logic [7:0] req_blue_in,
   input logic [7:0] req_alpha_in,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_alpha_out,
   input logic csr_valid,
   output logic csr_ready,
   input logic [7:0] csr_lightness_shift
);

   localparam int FW = hlt_pkg::FX_W;
   localparam int DS = hlt_pkg::DIV_STAGES;
   localparam int ST_A = 0;
   localparam int ST_B = 1;
   localparam int ST_C = ST_B + DS + 1;
   localparam int ST_D = ST_C + 1;
   localparam int ST_E = ST_D + 1;
   localparam int ST_F = ST_E + 1;
   localparam int ST_G = ST_F + 1;
   localparam int ST_H = ST_G + 1;
   localparam int NST = ST_H + 1;

   localparam logic [1:0] ARM_RISE = 2'd0;
   localparam logic [1:0] ARM_Q = 2'd1;
   localparam logic [1:0] ARM_FALL = 2'd2;
   localparam logic [1:0] ARM_P = 2'd3;

   logic [NST-1:0] valid_ff;
   logic [NST-1:0] adv;
   logic [7:0] shift_ff;

   always_comb begin
      adv[NST-1] = !valid_ff[NST-1] || rsp_ready;
      for (int i = NST - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         shift_ff <= hlt_pkg::SHIFT_RESET;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= (i == 0) ? req_valid : valid_ff[i-1];
            end
         end
         if (csr_valid) begin
            shift_ff <= csr_lightness_shift;
         end
      end
   end

   assign req_ready = adv[ST_A];
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff[ST_H];

   // stage A: channel * 65536 / 255 = channel * 257 + (channel == 255)
   logic [FW-1:0] xr_ff, xg_ff, xb_ff;
   logic [7:0] alpha_a_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_A]) begin
         xr_ff <= {1'b0, req_red_in, req_red_in} + FW'(req_red_in == 8'hFF);
         xg_ff <= {1'b0, req_green_in, req_green_in} + FW'(req_green_in == 8'hFF);
         xb_ff <= {1'b0, req_blue_in, req_blue_in} + FW'(req_blue_in == 8'hFF);
         alpha_a_ff <= req_alpha_in;
      end
   end

   // stage B: extremes, lightness, divider operands
   logic [FW-1:0] mx, mn, dd, hnum;
   logic [FW:0] msum;
   logic [FW-1:0] lum_b;
   logic grey_b;
   hlt_pkg::side_type side_b;
   logic [FW-1:0] sat_num_ff, hue_num_ff;
   logic [hlt_pkg::DEN_W-1:0] sat_den_ff, hue_den_ff;
   hlt_pkg::side_type side_b_ff;

   always_comb begin
      mx = (xr_ff > xg_ff) ? xr_ff : xg_ff;
      mx = (mx > xb_ff) ? mx : xb_ff;
      mn = (xr_ff < xg_ff) ? xr_ff : xg_ff;
      mn = (mn < xb_ff) ? mn : xb_ff;
      msum = {1'b0, mx} + {1'b0, mn};
      lum_b = msum[FW:1];
      dd = mx - mn;
      grey_b = (mx == mn);
      side_b.lum = lum_b;
      side_b.alpha = alpha_a_ff;
      side_b.grey = grey_b;
      if (mx == xr_ff) begin
         side_b.neg = (xg_ff < xb_ff);
         side_b.base = side_b.neg ? 3'd6 : 3'd0;
         hnum = side_b.neg ? (xb_ff - xg_ff) : (xg_ff - xb_ff);
      end else if (mx == xg_ff) begin
         side_b.neg = (xb_ff < xr_ff);
         side_b.base = 3'd2;
         hnum = side_b.neg ? (xr_ff - xb_ff) : (xb_ff - xr_ff);
      end else begin
         side_b.neg = (xr_ff < xg_ff);
         side_b.base = 3'd4;
         hnum = side_b.neg ? (xg_ff - xr_ff) : (xr_ff - xg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_B]) begin
         side_b_ff <= side_b;
         if (grey_b) begin
            sat_num_ff <= '0;
            hue_num_ff <= '0;
            sat_den_ff <= hlt_pkg::DEN_W'(1);
            hue_den_ff <= hlt_pkg::DEN_W'(1);
         end else begin
            sat_num_ff <= dd;
            hue_num_ff <= hnum;
            sat_den_ff <= (lum_b > hlt_pkg::FX_HALF) ? ({hlt_pkg::FX_ONE, 1'b0} - msum) : msum;
            hue_den_ff <= {1'b0, dd};
         end
      end
   end

   // divider stages
   logic [FW-1:0] sat_q, hue_q;
   hlt_pkg::side_type side_ff [DS];

   hlt_div u_sat_div (
      .clock(clock),
      .en(adv[ST_B+DS:ST_B+1]),
      .num(sat_num_ff),
      .den(sat_den_ff),
      .quo(sat_q)
   );

   hlt_div u_hue_div (
      .clock(clock),
      .en(adv[ST_B+DS:ST_B+1]),
      .num(hue_num_ff),
      .den(hue_den_ff),
      .quo(hue_q)
   );

   always_ff @(posedge clock) begin
      for (int k = 0; k < DS; k++) begin
         if (adv[ST_B+1+k]) begin
            side_ff[k] <= (k == 0) ? side_b_ff : side_ff[k-1];
         end
      end
   end

   // stage C: six times hue, shifted and clamped lightness
   hlt_pkg::side_type side_c;
   logic [7:0] shift_abs;
   logic [10:0] frac_y;
   logic [21:0] frac_p;
   logic [FW-1:0] shift_mag;
   logic signed [FW+1:0] lum_sum;
   logic [18:0] h6;
   logic [FW-1:0] lum_t;
   logic [18:0] h6_ff;
   logic [FW-1:0] lum_c_ff, sat_c_ff;
   logic [7:0] alpha_c_ff;
   logic grey_c_ff;

   always_comb begin
      side_c = side_ff[DS-1];
      shift_abs = shift_ff[7] ? (8'd0 - shift_ff) : shift_ff;
      frac_y = 11'(shift_abs * hlt_pkg::SHIFT_FRAC_MUL);
      frac_p = 22'(frac_y * hlt_pkg::SHIFT_RECIP);
      shift_mag = FW'(shift_abs * hlt_pkg::SHIFT_INT) + FW'(frac_p[21:16]);
      if (shift_ff[7]) begin
         lum_sum = $signed({2'b00, side_c.lum}) - $signed({2'b00, shift_mag});
      end else begin
         lum_sum = $signed({2'b00, side_c.lum}) + $signed({2'b00, shift_mag});
      end
      if (lum_sum < 0) begin
         lum_t = '0;
      end else if (lum_sum > $signed({2'b00, hlt_pkg::FX_ONE})) begin
         lum_t = hlt_pkg::FX_ONE;
      end else begin
         lum_t = lum_sum[FW-1:0];
      end
      if (side_c.neg) begin
         h6 = {side_c.base, 16'h0000} - {2'b00, hue_q};
      end else begin
         h6 = {side_c.base, 16'h0000} + {2'b00, hue_q};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_C]) begin
         h6_ff <= h6;
         lum_c_ff <= lum_t;
         sat_c_ff <= side_c.grey ? '0 : sat_q;
         alpha_c_ff <= side_c.alpha;
         grey_c_ff <= side_c.grey;
      end
   end

   // stage D: hue / 6 and lightness * saturation
   logic [36:0] hprod;
   logic [33:0] lsprod;
   logic [FW-1:0] hue_d_ff, lum_d_ff, sat_d_ff;
   logic [17:0] ls_d_ff;
   logic [7:0] alpha_d_ff;
   logic grey_d_ff;

   assign hprod = 37'(h6_ff * hlt_pkg::HUE_RECIP);
   assign lsprod = 34'(lum_c_ff * sat_c_ff);

   always_ff @(posedge clock) begin
      if (adv[ST_D]) begin
         hue_d_ff <= hprod[hlt_pkg::HUE_RECIP_SHIFT+FW-1:hlt_pkg::HUE_RECIP_SHIFT];
         ls_d_ff <= lsprod[33:16];
         lum_d_ff <= lum_c_ff;
         sat_d_ff <= sat_c_ff;
         alpha_d_ff <= alpha_c_ff;
         grey_d_ff <= grey_c_ff;
      end
   end

   // stage E: q and p
   logic signed [19:0] qv, pv;
   logic signed [19:0] q_e_ff, p_e_ff;
   logic [FW-1:0] hue_e_ff, lum_e_ff;
   logic [7:0] alpha_e_ff;
   logic grey_e_ff;

   always_comb begin
      if (lum_d_ff < hlt_pkg::FX_HALF) begin
         qv = $signed({3'b000, lum_d_ff}) + $signed({2'b00, ls_d_ff});
      end else begin
         qv = $signed({3'b000, lum_d_ff}) + $signed({3'b000, sat_d_ff})
              - $signed({2'b00, ls_d_ff});
      end
      pv = $signed({2'b00, lum_d_ff, 1'b0}) - qv;
      if (qv < pv) begin
         qv = pv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_E]) begin
         q_e_ff <= qv;
         p_e_ff <= pv;
         hue_e_ff <= hue_d_ff;
         lum_e_ff <= lum_d_ff;
         alpha_e_ff <= alpha_d_ff;
         grey_e_ff <= grey_d_ff;
      end
   end

   // stage F: per-channel hue offset, wrap and piece select
   logic signed [FW+1:0] tt;
   logic [FW-1:0] tw;
   logic [19:0] six_t;
   logic [2:0][18:0] factor;
   logic [2:0][1:0] arm;
   logic [19:0] diff;
   logic [2:0][18:0] factor_f_ff;
   logic [2:0][1:0] arm_f_ff;
   logic [17:0] diff_f_ff;
   logic signed [19:0] q_f_ff, p_f_ff;
   logic [FW-1:0] lum_f_ff;
   logic [7:0] alpha_f_ff;
   logic grey_f_ff;

   always_comb begin
      diff = 20'(q_e_ff - p_e_ff);
      for (int c = 0; c < 3; c++) begin
         if (c == 0) begin
            tt = $signed({2'b00, hue_e_ff}) + $signed({2'b00, hlt_pkg::FX_THIRD});
         end else if (c == 1) begin
            tt = $signed({2'b00, hue_e_ff});
         end else begin
            tt = $signed({2'b00, hue_e_ff}) - $signed({2'b00, hlt_pkg::FX_THIRD});
         end
         if (tt < 0) begin
            tt = tt + $signed({2'b00, hlt_pkg::FX_ONE});
         end
         if (tt > $signed({2'b00, hlt_pkg::FX_ONE})) begin
            tt = tt - $signed({2'b00, hlt_pkg::FX_ONE});
         end
         tw = tt[FW-1:0];
         six_t = 20'(tw * 3'd6);
         if (six_t < 20'(hlt_pkg::FX_ONE)) begin
            arm[c] = ARM_RISE;
            factor[c] = six_t[18:0];
         end else if ({tw, 1'b0} < 18'(hlt_pkg::FX_ONE)) begin
            arm[c] = ARM_Q;
            factor[c] = '0;
         end else if (19'(tw * 2'd3) < {hlt_pkg::FX_ONE, 1'b0}) begin
            arm[c] = ARM_FALL;
            factor[c] = 19'({hlt_pkg::FX_ONE, 2'b00} - six_t);
         end else begin
            arm[c] = ARM_P;
            factor[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_F]) begin
         factor_f_ff <= factor;
         arm_f_ff <= arm;
         diff_f_ff <= diff[17:0];
         q_f_ff <= q_e_ff;
         p_f_ff <= p_e_ff;
         lum_f_ff <= lum_e_ff;
         alpha_f_ff <= alpha_e_ff;
         grey_f_ff <= grey_e_ff;
      end
   end

   // stage G: (q - p) * factor
   logic [2:0][36:0] cprod;
   logic [2:0][20:0] cprod_g_ff;
   logic [2:0][1:0] arm_g_ff;
   logic signed [19:0] q_g_ff, p_g_ff;
   logic [FW-1:0] lum_g_ff;
   logic [7:0] alpha_g_ff;
   logic grey_g_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cprod[c] = 37'(diff_f_ff * factor_f_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_G]) begin
         for (int c = 0; c < 3; c++) begin
            cprod_g_ff[c] <= cprod[c][36:16];
         end
         arm_g_ff <= arm_f_ff;
         q_g_ff <= q_f_ff;
         p_g_ff <= p_f_ff;
         lum_g_ff <= lum_f_ff;
         alpha_g_ff <= alpha_f_ff;
         grey_g_ff <= grey_f_ff;
      end
   end

   // stage H: channel value, clamp, scale to byte
   logic signed [21:0] cv;
   logic [FW-1:0] cu;
   logic [24:0] scaled;
   logic [2:0][7:0] chan_out;
   logic [2:0][7:0] chan_ff;
   logic [7:0] alpha_h_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (grey_g_ff) begin
            cv = $signed({5'b00000, lum_g_ff});
         end else begin
            case (arm_g_ff[c]) inside
               ARM_RISE, ARM_FALL: cv = 22'(p_g_ff) + $signed({1'b0, cprod_g_ff[c]});
               ARM_Q: cv = 22'(q_g_ff);
               default: cv = 22'(p_g_ff);
            endcase
         end
         if (cv < 0) begin
            cu = '0;
         end else if (cv > $signed({5'b00000, hlt_pkg::FX_ONE})) begin
            cu = hlt_pkg::FX_ONE;
         end else begin
            cu = cv[FW-1:0];
         end
         scaled = {cu, 8'h00} - 25'(cu);
         chan_out[c] = scaled[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_H]) begin
         chan_ff <= chan_out;
         alpha_h_ff <= alpha_g_ff;
      end
   end

   assign rsp_red_out = chan_ff[0];
   assign rsp_green_out = chan_ff[1];
   assign rsp_blue_out = chan_ff[2];
   assign rsp_alpha_out = alpha_h_ff;

endmodule

/* rtl/hlt_checker.sv */
module hlt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic [7:0] rsp_alpha_out,
   input logic csr_ready
);

   // a stalled response keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_alpha_out))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a draining output never backs up the request side
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request blocked while response side ready");

   a_csr: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> csr_ready)
      else $error("config port not ready");

endmodule

bind hsl_lightness_tint hlt_checker u_hlt_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_red_out(rsp_red_out),
   .rsp_green_out(rsp_green_out),
   .rsp_blue_out(rsp_blue_out),
   .rsp_alpha_out(rsp_alpha_out),
   .csr_ready(csr_ready)
);
